// ===== rtl/sbbd_pkg.sv =====
`default_nettype none

package sbbd_pkg;

  // Stream position and block byte counters are fixed by the stream_length register width
  localparam int unsigned POS_W = 32;

  // Register index decoded from paddr[2]
  localparam logic [0:0] REG_STREAM_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_last;
    logic       frame_error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sbbd_core.sv =====
`default_nettype none

module sbbd_core import sbbd_pkg::*; #(
  parameter int unsigned LENGTH_BITS      = 32,
  parameter int unsigned MAX_PREFIX_BYTES = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic [POS_W-1:0] stream_length_i,
  output logic                  emit_o,
  output res_t                  res_o
);

  localparam int unsigned PC_W  = $clog2(MAX_PREFIX_BYTES + 1);
  localparam int unsigned CMP_W = (LENGTH_BITS > POS_W) ? LENGTH_BITS : POS_W;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] accum_q, accum_d;
  logic [POS_W-1:0]       left_q, left_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [PC_W-1:0]        cnt_q, cnt_d;

  logic                   drop;
  logic [POS_W-1:0]       pos_inc;
  logic [POS_W-1:0]       left_dec;
  logic                   terminal;
  logic                   ovf;
  logic [LENGTH_BITS-1:0] accum_sh;
  logic [PC_W-1:0]        cnt_inc;
  logic [POS_W-1:0]       stream_rem;
  logic [CMP_W-1:0]       accum_x;
  logic                   too_long;
  logic                   hdr_err;

  assign drop       = (phase_q == PH_ERROR) || (pos_q >= stream_length_i);
  assign pos_inc    = pos_q + POS_W'(1);
  assign left_dec   = (left_q == '0) ? '0 : left_q - POS_W'(1);
  // last byte of the stream closes a header even without its stop bit
  assign terminal   = byte_i[7] || (pos_inc >= stream_length_i);
  assign ovf        = |accum_q[LENGTH_BITS-1 -: 7];
  assign accum_sh   = {accum_q[LENGTH_BITS-8:0], byte_i[6:0]};
  assign cnt_inc    = cnt_q + PC_W'(1);
  assign stream_rem = stream_length_i - pos_inc;
  assign accum_x    = CMP_W'(accum_sh);
  assign too_long   = terminal ? (accum_x > CMP_W'(stream_rem))
                               : (cnt_inc >= PC_W'(MAX_PREFIX_BYTES));
  assign hdr_err    = ovf || too_long;

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    left_d  = left_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    if (step_i && !drop) begin
      pos_d = pos_inc;
      case (phase_q)
        PH_PAYLOAD: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (hdr_err) begin
            phase_d = PH_ERROR;
            accum_d = '0;
            cnt_d   = '0;
            left_d  = '0;
          end else if (!terminal) begin
            accum_d = accum_sh;
            cnt_d   = cnt_inc;
          end else begin
            cnt_d   = '0;
            accum_d = '0;
            // zero-length block: stay in header
            if (accum_sh != '0) begin
              left_d  = POS_W'(accum_x);
              phase_d = PH_PAYLOAD;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    emit_o = 1'b0;
    res_o  = '0;
    if (step_i && !drop) begin
      case (phase_q)
        PH_PAYLOAD: begin
          emit_o           = 1'b1;
          res_o.data_byte  = byte_i;
          res_o.block_last = (left_dec == '0);
        end
        PH_HEADER: begin
          if (hdr_err) begin
            emit_o            = 1'b1;
            res_o.frame_error = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      accum_q <= '0;
      left_q  <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  a_payload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> (left_q != '0) && (accum_q == '0))
    else $error("payload phase with empty block count or pending length");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR |=> phase_q == PH_ERROR)
    else $error("left error phase without reset");

  a_prefix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < PC_W'(MAX_PREFIX_BYTES))
    else $error("header byte count past limit");

  a_err_enters_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.frame_error |=> phase_q == PH_ERROR)
    else $error("error result without entering error phase");

  a_last_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.block_last |=> phase_q == PH_HEADER)
    else $error("block end not followed by header phase");

endmodule

`default_nettype wire

// ===== rtl/stop_bit_block_deframer.sv =====
// Stop-bit length-prefixed block deframer.
// Input stream (s_axis_*): one raw byte per transfer. The stream is a run of
// blocks, each led by a length header of 7 bits per byte, MSB group first,
// closed by a byte with bit 7 set. Header bytes give no output.
// Output stream (m_axis_*): payload bytes in tdata, tlast on the final byte of
// each block, tuser = frame error. On a header error (length past stream end,
// length overflow, header too long) one transfer with tuser high and tdata,
// tlast low is sent, then every byte is swallowed until reset.
// APB: register 0 (addr 0x0) is stream_length, total bytes incl. headers;
// bytes past it are dropped. Write it only while the block is idle.
// A byte passes the input register, then the output register, on its way to m_axis.
// Throughput: one byte per cycle while the output is not stalled; an input
// register and an output register each hold one item, so one more input
// transfer is taken while an output waits. When m_axis_tready is low, the
// output holds and the input stage fills, then s_axis_tready drops. Reset
// empties both stages, clears the parse state and sets stream_length to all ones.

`default_nettype none

module stop_bit_block_deframer import sbbd_pkg::*; #(
  parameter int unsigned LENGTH_BITS      = 32,
  parameter int unsigned MAX_PREFIX_BYTES = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] data_byte
  output logic             m_axis_tlast_o,   // block_last
  output logic             m_axis_tuser_o,   // [0] frame_error
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  logic [POS_W-1:0] stream_length_q;
  logic             in_vld_q, in_vld_d;
  logic [7:0]       in_byte_q;
  logic             out_vld_q, out_vld_d;
  res_t             out_res_q;
  logic             out_free;
  logic             step;
  logic             emit;
  res_t             res;
  logic             cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2:2] == REG_STREAM_LENGTH);
  assign prdata_o = (paddr_i[2:2] == REG_STREAM_LENGTH) ? stream_length_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '1;
    end else if (cfg_wr) begin
      stream_length_q <= pwdata_i;
    end
  end

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  assign out_vld_d = out_free ? emit : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (out_free && emit) begin
      out_res_q <= res;
    end
  end

  sbbd_core #(
    .LENGTH_BITS      (LENGTH_BITS),
    .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .byte_i          (in_byte_q),
    .stream_length_i (stream_length_q),
    .emit_o          (emit),
    .res_o           (res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_res_q.data_byte;
  assign m_axis_tlast_o  = out_res_q.block_last;
  assign m_axis_tuser_o  = out_res_q.frame_error;

endmodule

`default_nettype wire

// ===== dv/tb_stop_bit_block_deframer.sv =====
`timescale 1ns / 100ps

module tb_stop_bit_block_deframer;
  import sbbd_pkg::*;

  localparam int unsigned MAX_PFX     = 5;
  localparam int unsigned RAND_ITEMS  = 2000;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned NROWS       = 44;

  localparam logic [2:0] ADDR_LEN   = {REG_STREAM_LENGTH, 2'b00};
  localparam logic [2:0] ADDR_SPARE = 3'd4;  // decodes to no register

  localparam res_t NO_RES  = '0;
  localparam res_t ERR_RES = '{8'h00, 1'b0, 1'b1};

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_LEN_REL,    // stream_length = bytes consumed so far + val
    ROW_LEN_ABS,
    ROW_SPARE_REG
  } row_kind_e;

  typedef struct packed {
    logic [1:0]  grp;   // 0: opening rows, 1..3: one of the error endings
    row_kind_e   kind;
    logic [31:0] val;
    logic        chk;   // want is typed in
    res_t        want;
  } stim_row_t;

  stim_row_t dir_rows [NROWS] = '{
    '{2'd0, ROW_BYTE,      32'h80, 1'b0, NO_RES},  // zero-length block
    '{2'd0, ROW_BYTE,      32'h81, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{2'd0, ROW_BYTE,      32'h82, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0}},
    '{2'd0, ROW_BYTE,      32'h7F, 1'b1, '{8'h7F, 1'b1, 1'b0}},
    '{2'd0, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h83, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'hA5, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h5A, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h3C, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h00, 1'b0, NO_RES},  // longest legal header
    '{2'd0, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h81, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h55, 1'b1, '{8'h55, 1'b1, 1'b0}},
    '{2'd0, ROW_SPARE_REG, 32'h1234_5678, 1'b0, NO_RES},
    '{2'd0, ROW_LEN_REL,   32'd3,  1'b0, NO_RES},  // block ends at stream end
    '{2'd0, ROW_BYTE,      32'h82, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h11, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h22, 1'b1, '{8'h22, 1'b1, 1'b0}},
    '{2'd0, ROW_BYTE,      32'hEE, 1'b0, NO_RES},  // past end, dropped
    '{2'd0, ROW_LEN_REL,   32'd1,  1'b0, NO_RES},  // header cut by stream end
    '{2'd0, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h9C, 1'b0, NO_RES},
    '{2'd0, ROW_LEN_ABS,   32'h0,  1'b0, NO_RES},
    '{2'd0, ROW_BYTE,      32'h81, 1'b0, NO_RES},
    '{2'd0, ROW_LEN_ABS,   32'hFFFF_FFFF, 1'b0, NO_RES},
    '{2'd1, ROW_LEN_REL,   32'd3,  1'b0, NO_RES},  // length past stream end
    '{2'd1, ROW_BYTE,      32'h84, 1'b1, ERR_RES},
    '{2'd1, ROW_BYTE,      32'h81, 1'b0, NO_RES},
    '{2'd2, ROW_BYTE,      32'h7F, 1'b0, NO_RES},  // length overflow
    '{2'd2, ROW_BYTE,      32'h7F, 1'b0, NO_RES},
    '{2'd2, ROW_BYTE,      32'h7F, 1'b0, NO_RES},
    '{2'd2, ROW_BYTE,      32'h7F, 1'b0, NO_RES},
    '{2'd2, ROW_BYTE,      32'hFF, 1'b1, ERR_RES},
    '{2'd2, ROW_BYTE,      32'h81, 1'b0, NO_RES},
    '{2'd3, ROW_BYTE,      32'h00, 1'b0, NO_RES},  // header too long
    '{2'd3, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd3, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd3, ROW_BYTE,      32'h00, 1'b0, NO_RES},
    '{2'd3, ROW_BYTE,      32'h00, 1'b1, ERR_RES},
    '{2'd3, ROW_BYTE,      32'h81, 1'b0, NO_RES}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;
  logic [31:0] prdata_o;
  logic        pready_o;

  // deframer state as predicted
  phase_e      dfr_phase = PH_HEADER;
  logic [31:0] dfr_acc   = '0;
  logic [31:0] dfr_left  = '0;
  logic [31:0] dfr_pos   = '0;
  logic [31:0] dfr_slen  = 32'hFFFF_FFFF;
  logic [7:0]  dfr_pfx   = '0;

  res_t        out_bytes_q [$];
  int          mism_cnt   = 0;
  int          quiet_cyc  = 0;
  int          stall_left = 0;
  logic [31:0] cyc        = '0;

  stop_bit_block_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    mism_cnt++;
    if (mism_cnt <= 10) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output res_t r);
    logic        term;
    logic [31:0] room;
    got = 1'b0;
    r   = NO_RES;
    if (dfr_phase == PH_ERROR || dfr_pos >= dfr_slen) return;
    dfr_pos++;
    if (dfr_phase == PH_PAYLOAD) begin
      if (dfr_left != 0) dfr_left--;
      r.data_byte  = b;
      r.block_last = (dfr_left == 0);
      got          = 1'b1;
      if (dfr_left == 0) dfr_phase = PH_HEADER;
      return;
    end
    term = b[7] || (dfr_pos >= dfr_slen);
    // overflow is judged before the new group is shifted in
    if (dfr_acc[31:25] == 0) begin
      dfr_acc = {dfr_acc[24:0], b[6:0]};
      if (dfr_pfx != 8'hFF) dfr_pfx++;
      if (!term) begin
        if (dfr_pfx < MAX_PFX) return;
      end else begin
        room = dfr_slen - dfr_pos;
        if (dfr_acc <= room) begin
          dfr_pfx = '0;
          if (dfr_acc != 0) begin
            dfr_left  = dfr_acc;
            dfr_acc   = '0;
            dfr_phase = PH_PAYLOAD;
          end
          return;
        end
      end
    end
    dfr_phase = PH_ERROR;
    dfr_acc   = '0;
    dfr_pfx   = '0;
    dfr_left  = '0;
    r         = ERR_RES;
    got       = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    int   gap;
    int   k;
    bit   got;
    res_t r;
    gap = 0;
    if (cyc[10:9] != 2'd1) begin
      k = $urandom_range(0, 99);
      if (k >= 92) gap = $urandom_range(8, 40);
      else if (k >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    deframe_byte(b, got, r);
    if (typed) out_bytes_q.push_back(want);
    else if (got) out_bytes_q.push_back(r);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // only with the deframer drained; reads stream_length back afterwards
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] v);
    logic [31:0] rd;
    s_axis_tvalid <= 1'b0;
    while (out_bytes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (addr == ADDR_LEN) dfr_slen = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LEN;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    rd = prdata_o;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== dfr_slen) begin
      note_mismatch($sformatf("stream_length read %08h, want %08h", rd, dfr_slen));
    end
  endtask

  function automatic logic [63:0] room_left();
    return (dfr_slen > dfr_pos) ? {32'd0, dfr_slen - dfr_pos} : 64'd0;
  endfunction

  task automatic run_rows(input logic [1:0] grp);
    for (int i = 0; i < NROWS; i++) begin
      if (dir_rows[i].grp == grp) begin
        case (dir_rows[i].kind)
          ROW_BYTE: begin
            send_byte(dir_rows[i].val[7:0], dir_rows[i].chk, dir_rows[i].want);
          end
          ROW_LEN_REL: begin
            write_reg(ADDR_LEN, dfr_pos + dir_rows[i].val);
          end
          ROW_LEN_ABS: begin
            write_reg(ADDR_LEN, dir_rows[i].val);
          end
          default: begin
            write_reg(ADDR_SPARE, dir_rows[i].val);
          end
        endcase
      end
    end
  endtask

  // one stream_length setting, then well-formed blocks that fit in it; a
  // block may be left open and then finished or cut under the next setting
  task automatic random_phase();
    logic [31:0] v;
    logic [63:0] room;
    logic [7:0]  hb;
    int          n;
    int          blen;
    int          hlen;
    int          k;
    k = $urandom_range(0, 15);
    if (k == 0) v = 32'hFFFF_FFFF;
    else if (k == 1) v = dfr_pos;
    else if (k == 2) v = 32'h0;
    else v = dfr_pos + 32'($urandom_range(1, 400));
    write_reg(ADDR_LEN, v);
    n    = $urandom_range(10, 200);
    room = room_left();
    while (n > 0 && room != 0) begin
      if (dfr_phase == PH_PAYLOAD) begin
        send_byte(8'($urandom), 1'b0, NO_RES);
        n--;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70) blen = $urandom_range(0, 8);
        else if (k < 95) blen = $urandom_range(9, 140);
        else blen = $urandom_range(141, 400);
        hlen = (blen < 128) ? 1 : 2;
        // leading zero groups are legal up to the header size limit
        if ($urandom_range(0, 7) == 0) hlen += $urandom_range(1, 3);
        if (64'(blen + hlen) > room) begin
          blen = (room < 129) ? int'(room) - 1 : int'(room) - 2;
          hlen = (blen < 128) ? 1 : 2;
        end
        for (int g = hlen - 1; g >= 0; g--) begin
          hb    = 8'((blen >> (7 * g)) & 32'h7F);
          hb[7] = (g == 0);
          send_byte(hb, 1'b0, NO_RES);
        end
        n -= hlen;
      end
      room = room_left();
    end
    if (room == 0) begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, NO_RES);
    end
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (cyc[9:8] != 2'd0 && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                    : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (out_bytes_q.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer data=%02h last=%b err=%b",
                                m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o));
      end else begin
        want = out_bytes_q.pop_front();
        if (m_axis_tdata_o !== want.data_byte || m_axis_tlast_o !== want.block_last ||
            m_axis_tuser_o !== want.frame_error) begin
          note_mismatch($sformatf("data=%02h last=%b err=%b, want data=%02h last=%b err=%b",
                                  m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o,
                                  want.data_byte, want.block_last, want.frame_error));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
    if (quiet_cyc == QUIET_LIMIT) begin
      $display("FAIL stop_bit_block_deframer");
      $finish;
    end
  end

  initial begin
    int err_grp;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_rows(2'd0);
    while (dfr_pos < RAND_ITEMS && dfr_phase != PH_ERROR) random_phase();
    // close any open block before the sticky error ends the stream
    write_reg(ADDR_LEN, 32'hFFFF_FFFF);
    while (dfr_phase == PH_PAYLOAD) send_byte(8'($urandom), 1'b0, NO_RES);
    err_grp = $urandom_range(1, 3);
    run_rows(2'(err_grp));
    repeat (6) send_byte(8'($urandom), 1'b0, NO_RES);
    s_axis_tvalid <= 1'b0;
    while (out_bytes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("PASS stop_bit_block_deframer");
    end else begin
      $display("FAIL stop_bit_block_deframer");
    end
    $finish;
  end

endmodule
